### hdl/pfr_pkg.sv
// ============================================================================
// pfr_pkg
// Shared constants, types and helpers of the complex polyphase resampler.
// ============================================================================
`default_nettype none

package pfr_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int TAP_AW      = $clog2(MAX_TAPS);
    localparam int MAX_INTERP  = 16;
    localparam int DECIM_LIMIT = 16;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC        = SAMPLE_W - 1;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int ACC_W       = PROD_W + 2 + TAP_AW;
    localparam int QW          = ACC_W - FRAC;

    localparam int FACTOR_W    = 5;
    localparam int TAPCNT_W    = 7;
    localparam int PHASE_W     = $clog2(MAX_INTERP);
    localparam int DPH_W       = $clog2(DECIM_LIMIT);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

    localparam logic [FACTOR_W-1:0] INTERP_RST = 5'd1;
    localparam logic [FACTOR_W-1:0] DECIM_RST  = 5'd1;
    localparam logic [TAPCNT_W-1:0] TAPS_RST   = 7'd64;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [QW-1:0] Q_HI =
        {{(QW-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_LO =
        {{(QW-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } cplx_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PHASE = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] v;
        logic signed [QW-1:0]    q;
        v = acc + RND_HALF;
        q = $signed(v[ACC_W-1:FRAC]);
        if (q > Q_HI)
            return Q_HI[SAMPLE_W-1:0];
        else if (q < Q_LO)
            return Q_LO[SAMPLE_W-1:0];
        else
            return q[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/polyphase_resampling_fir.sv
// ============================================================================
// polyphase_resampling_fir
// Complex polyphase resampler: interpolate by L, decimate by M, Q1.15.
// ============================================================================
// A load item is taken in the idle state. For a sample item each phase passes
//   S_PHASE; one that emits a result then runs S_MAC (one complex MAC a cycle
//   through the coefficient and delay read ports), S_DRAIN and S_EMIT.
// Reset sets the settings to their defaults and clears the control state, the
//   decimation counter, the delay fill count and the coefficient valid bits
//   at once; no clearing pass.
`default_nettype none

module polyphase_resampling_fir (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 cmd,
    input  wire logic signed [pfr_pkg::SAMPLE_W-1:0]  sample_re,
    input  wire logic signed [pfr_pkg::SAMPLE_W-1:0]  sample_im,
    input  wire logic [pfr_pkg::TAP_AW-1:0]           coef_index,
    input  wire logic signed [pfr_pkg::SAMPLE_W-1:0]  coef_re,
    input  wire logic signed [pfr_pkg::SAMPLE_W-1:0]  coef_im,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [pfr_pkg::SAMPLE_W-1:0]       out_re,
    output logic signed [pfr_pkg::SAMPLE_W-1:0]       out_im,
    output logic                                      last
);
    import pfr_pkg::*;

    cplx_t                       dly_mem [MAX_TAPS];
    cplx_t                       coef_mem [MAX_TAPS];
    cplx_t                       dly_q_reg;
    cplx_t                       coef_q_reg;

    logic [FACTOR_W-1:0]         interp_reg;
    logic [FACTOR_W-1:0]         decim_reg;
    logic [TAPCNT_W-1:0]         taps_reg;
    logic [FACTOR_W-1:0]         l_eff;
    logic [FACTOR_W-1:0]         m_eff;
    logic [TAPCNT_W-1:0]         taps_eff;

    state_t                      state_reg, state_next;
    logic [PHASE_W-1:0]          ph_reg, ph_next;
    logic [DPH_W-1:0]            dp_reg, dp_next;
    logic [TAP_AW-1:0]           j_reg, j_next;
    logic [TAPCNT_W-1:0]         base_reg, base_next;
    logic [TAP_AW-1:0]           wp_reg, wp_next;
    logic [TAPCNT_W-1:0]         fill_reg, fill_next;
    logic [MAX_TAPS-1:0]         cvld_reg;

    logic                        rd_vld_reg, prod_vld_reg;
    logic                        dv_reg, cv_reg;
    logic signed [PROD_W-1:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_W-1:0]     acc_re_reg, acc_im_reg;

    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_re_reg, out_im_reg;
    logic                        out_last_reg;

    logic                        in_acc, smp_acc, load_acc;
    logic                        issue, acc_clr, emit, out_free;
    logic                        ph_done;
    logic [DPH_W-1:0]            dp_adv;
    logic [TAP_AW-1:0]           dly_ra, coef_ra;
    logic [TAPCNT_W:0]           reach;
    logic [TAPCNT_W-1:0]         caddr;
    cplx_t                       a_m, c_m;

    assign l_eff = (interp_reg == '0) ? FACTOR_W'(1) :
                   (interp_reg > FACTOR_W'(MAX_INTERP)) ? FACTOR_W'(MAX_INTERP) : interp_reg;
    assign m_eff = (decim_reg == '0) ? FACTOR_W'(1) :
                   (decim_reg > FACTOR_W'(DECIM_LIMIT)) ? FACTOR_W'(DECIM_LIMIT) : decim_reg;
    assign taps_eff = (taps_reg > TAPCNT_W'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS) : taps_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign smp_acc  = in_acc && !cmd;
    assign load_acc = in_acc && cmd;
    assign out_free = !out_valid_reg || out_ready;

    assign reach   = {1'b0, base_reg} + (TAPCNT_W+1)'(l_eff);
    assign caddr   = base_reg + TAPCNT_W'(ph_reg);
    assign coef_ra = caddr[TAP_AW-1:0];
    assign dly_ra  = wp_reg - j_reg;
    assign ph_done = ((FACTOR_W)'(ph_reg) == l_eff - FACTOR_W'(1));
    assign dp_adv  = ((FACTOR_W)'(dp_reg) + FACTOR_W'(1) >= m_eff) ? '0 : dp_reg + DPH_W'(1);

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        dp_next    = dp_reg;
        j_next     = j_reg;
        base_next  = base_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        issue      = 1'b0;
        acc_clr    = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (smp_acc)
                begin
                    wp_next = wp_reg + TAP_AW'(1);
                    if (fill_reg < TAPCNT_W'(MAX_TAPS))
                        fill_next = fill_reg + TAPCNT_W'(1);
                    ph_next    = '0;
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                if (dp_reg == '0)
                begin
                    j_next     = '0;
                    base_next  = '0;
                    acc_clr    = 1'b1;
                    state_next = S_MAC;
                end
                else
                begin
                    dp_next = dp_adv;
                    if (ph_done)
                        state_next = S_IDLE;
                    else
                        ph_next = ph_reg + PHASE_W'(1);
                end
            end
            S_MAC:
            begin
                if (reach <= (TAPCNT_W+1)'(taps_eff))
                begin
                    issue     = 1'b1;
                    j_next    = j_reg + TAP_AW'(1);
                    base_next = reach[TAPCNT_W-1:0];
                end
                else
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    dp_next = dp_adv;
                    if (ph_done)
                        state_next = S_IDLE;
                    else
                    begin
                        ph_next    = ph_reg + PHASE_W'(1);
                        state_next = S_PHASE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg    <= INTERP_RST;
            decim_reg     <= DECIM_RST;
            taps_reg      <= TAPS_RST;
            state_reg     <= S_IDLE;
            ph_reg        <= '0;
            dp_reg        <= '0;
            j_reg         <= '0;
            base_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            cvld_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INTERP: interp_reg <= cfg_data[FACTOR_W-1:0];
                    CFG_DECIM:  decim_reg  <= cfg_data[FACTOR_W-1:0];
                    CFG_TAPS:   taps_reg   <= cfg_data[TAPCNT_W-1:0];
                    default:    ;
                endcase
            end
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            dp_reg       <= dp_next;
            j_reg        <= j_next;
            base_reg     <= base_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (load_acc)
                cvld_reg[coef_index] <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
            dly_mem[wp_next] <= '{re: sample_re, im: sample_im};
        dly_q_reg <= dly_mem[dly_ra];
    end

    always_ff @(posedge clk)
    begin
        if (load_acc)
            coef_mem[coef_index] <= '{re: coef_re, im: coef_im};
        coef_q_reg <= coef_mem[coef_ra];
    end

    assign a_m = dv_reg ? dly_q_reg : '0;
    assign c_m = cv_reg ? coef_q_reg : '0;

    always_ff @(posedge clk)
    begin
        dv_reg   <= (TAPCNT_W'(j_reg) < fill_reg);
        cv_reg   <= cvld_reg[coef_ra];
        p_rr_reg <= a_m.re * c_m.re;
        p_ii_reg <= a_m.im * c_m.im;
        p_ri_reg <= a_m.re * c_m.im;
        p_ir_reg <= a_m.im * c_m.re;
        if (acc_clr)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
        end
        if (emit)
        begin
            out_re_reg   <= round_sat(acc_re_reg);
            out_im_reg   <= round_sat(acc_im_reg);
            out_last_reg <= ((FACTOR_W+1)'(ph_reg) + (FACTOR_W+1)'(m_eff)
                             >= (FACTOR_W+1)'(l_eff));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

### hdl/pfr_checker.sv
// ============================================================================
// pfr_checker
// Port-level checks of the polyphase resampler, bound to the top level.
// ============================================================================
`default_nettype none

module pfr_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic                                 cmd,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic signed [pfr_pkg::SAMPLE_W-1:0]  out_re,
    input  wire logic signed [pfr_pkg::SAMPLE_W-1:0]  out_im,
    input  wire logic                                 last
);
    import pfr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_re) && $stable(out_im) && $stable(last))
        else $error("result item changed while stalled");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd && !out_valid |=> !out_valid)
        else $error("load item produced a result");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !cmd |=> !in_ready)
        else $error("item accepted while a sample is in progress");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !cmd && !out_valid |=> !out_valid)
        else $error("result appeared directly after sample accept");

endmodule

bind polyphase_resampling_fir pfr_checker u_pfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_re    (out_re),
    .out_im    (out_im),
    .last      (last)
);

`default_nettype wire

### dv/polyphase_resampling_fir_test.sv
`timescale 1ns / 100ps
// ============================================================================
// polyphase_resampling_fir_test
// Self-checking bench for the complex polyphase resampler. It streams
// coefficient loads and samples through the input handshake and predicts
// every filtered output in a scoreboard that keeps its own delay line,
// coefficient store and decimation counter. It checks each output in order
// while both handshakes stall at random, with register settings changed
// between phases.
// ============================================================================

module polyphase_resampling_fir_test;
    import pfr_pkg::*;

    localparam logic                 CMD_SAMPLE    = 1'b0;
    localparam logic                 CMD_LOAD      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
    localparam int                   SETTLE_CYCLES = 48;
    localparam int                   HOLD_CYCLES   = 400;
    localparam int                   RANDOM_ITEMS  = 430;

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       last;
    } fir_out_t;

    class fir_scoreboard;
        logic signed [SAMPLE_W-1:0] line_re[MAX_TAPS];
        logic signed [SAMPLE_W-1:0] line_im[MAX_TAPS];
        logic signed [SAMPLE_W-1:0] tap_re[MAX_TAPS];
        logic signed [SAMPLE_W-1:0] tap_im[MAX_TAPS];
        logic [DPH_W-1:0]           decim_cnt;
        logic [FACTOR_W-1:0]        interp_reg;
        logic [FACTOR_W-1:0]        decim_reg;
        logic [TAPCNT_W-1:0]        taps_reg;
        fir_out_t                   pending_out[$];
        int                         mismatches;

        function new();
            foreach (line_re[k])
            begin
                line_re[k] = '0;
                line_im[k] = '0;
                tap_re[k]  = '0;
                tap_im[k]  = '0;
            end
            decim_cnt  = '0;
            interp_reg = INTERP_RST;
            decim_reg  = DECIM_RST;
            taps_reg   = TAPS_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTERP: interp_reg = data[FACTOR_W-1:0];
                CFG_DECIM:  decim_reg  = data[FACTOR_W-1:0];
                CFG_TAPS:   taps_reg   = data[TAPCNT_W-1:0];
                default:    ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] to_q15(longint acc);
            longint q;
            longint hi;
            hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
            q  = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (q > hi)
                q = hi;
            if (q < -hi - 1)
                q = -hi - 1;
            return q[SAMPLE_W-1:0];
        endfunction

        function void take_item(logic c,
                                logic signed [SAMPLE_W-1:0] s_re,
                                logic signed [SAMPLE_W-1:0] s_im,
                                logic [TAP_AW-1:0] idx,
                                logic signed [SAMPLE_W-1:0] c_re,
                                logic signed [SAMPLE_W-1:0] c_im);
            int       l;
            int       m;
            int       n_taps;
            int       per_phase;
            int       ci;
            int       k;
            int       ph;
            int       count;
            longint   acc_re;
            longint   acc_im;
            longint   d_re;
            longint   d_im;
            longint   w_re;
            longint   w_im;
            fir_out_t r;
            if (c == CMD_LOAD)
            begin
                tap_re[idx] = c_re;
                tap_im[idx] = c_im;
                return;
            end
            l = (interp_reg == 0) ? 1 : int'(interp_reg);
            if (l > MAX_INTERP)
                l = MAX_INTERP;
            m = (decim_reg == 0) ? 1 : int'(decim_reg);
            if (m > DECIM_LIMIT)
                m = DECIM_LIMIT;
            n_taps = (int'(taps_reg) > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
            per_phase = n_taps / l;
            for (k = MAX_TAPS - 1; k > 0; k--)
            begin
                line_re[k] = line_re[k-1];
                line_im[k] = line_im[k-1];
            end
            line_re[0] = s_re;
            line_im[0] = s_im;
            count = 0;
            for (ph = 0; ph < l; ph++)
            begin
                if (decim_cnt == 0)
                begin
                    acc_re = 0;
                    acc_im = 0;
                    for (k = 0; k < per_phase; k++)
                    begin
                        ci = k * l + ph;
                        if (ci < MAX_TAPS)
                        begin
                            d_re = line_re[k];
                            d_im = line_im[k];
                            w_re = tap_re[ci];
                            w_im = tap_im[ci];
                            acc_re += d_re * w_re - d_im * w_im;
                            acc_im += d_re * w_im + d_im * w_re;
                        end
                    end
                    r.re   = to_q15(acc_re);
                    r.im   = to_q15(acc_im);
                    r.last = 1'b0;
                    pending_out.push_back(r);
                    count++;
                end
                decim_cnt = (int'(decim_cnt) + 1 >= m) ? '0 : decim_cnt + 1'b1;
            end
            if (count > 0)
            begin
                r = pending_out.pop_back();
                r.last = 1'b1;
                pending_out.push_back(r);
            end
        endfunction

        function void check_output(logic signed [SAMPLE_W-1:0] o_re,
                                   logic signed [SAMPLE_W-1:0] o_im,
                                   logic o_last);
            fir_out_t e;
            if (pending_out.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output: expected none, got re %0d im %0d last %0b",
                         $time, o_re, o_im, o_last);
                return;
            end
            e = pending_out.pop_front();
            if (o_re !== e.re)
            begin
                mismatches++;
                $display("%0t: out_re: expected %0d, got %0d", $time, e.re, o_re);
            end
            if (o_im !== e.im)
            begin
                mismatches++;
                $display("%0t: out_im: expected %0d, got %0d", $time, e.im, o_im);
            end
            if (o_last !== e.last)
            begin
                mismatches++;
                $display("%0t: last: expected %0b, got %0b", $time, e.last, o_last);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        cmd;
    logic signed [SAMPLE_W-1:0]  sample_re;
    logic signed [SAMPLE_W-1:0]  sample_im;
    logic [TAP_AW-1:0]           coef_index;
    logic signed [SAMPLE_W-1:0]  coef_re;
    logic signed [SAMPLE_W-1:0]  coef_im;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [SAMPLE_W-1:0]  out_re;
    logic signed [SAMPLE_W-1:0]  out_im;
    logic                        last;

    fir_scoreboard sb;
    logic          hold_request;
    logic          quiet_in;

    polyphase_resampling_fir dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .sample_re  (sample_re),
        .sample_im  (sample_im),
        .coef_index (coef_index),
        .coef_re    (coef_re),
        .coef_im    (coef_im),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_re     (out_re),
        .out_im     (out_im),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 64);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_q15();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input logic c,
                             input logic signed [SAMPLE_W-1:0] s_re,
                             input logic signed [SAMPLE_W-1:0] s_im,
                             input logic [TAP_AW-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] c_re,
                             input logic signed [SAMPLE_W-1:0] c_im);
        int unsigned gap;
        gap = quiet_in ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        sample_re  <= s_re;
        sample_im  <= s_im;
        coef_index <= idx;
        coef_re    <= c_re;
        coef_im    <= c_im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_item(c, s_re, s_im, idx, c_re, c_im);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s_re,
                               input logic signed [SAMPLE_W-1:0] s_im);
        send_item(CMD_SAMPLE, s_re, s_im, TAP_AW'($urandom_range(0, MAX_TAPS - 1)),
                  rand_q15(), rand_q15());
    endtask

    task automatic send_load(input logic [TAP_AW-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] c_re,
                             input logic signed [SAMPLE_W-1:0] c_im);
        send_item(CMD_LOAD, rand_q15(), rand_q15(), idx, c_re, c_im);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] l_val,
                                 input logic [CFG_DATA_W-1:0] m_val,
                                 input logic [CFG_DATA_W-1:0] t_val,
                                 input logic spare);
        write_reg(CFG_INTERP, l_val);
        write_reg(CFG_DECIM, m_val);
        write_reg(CFG_TAPS, t_val);
        if (spare)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 127)));
        cfg_we <= 1'b0;
    endtask

    initial
    begin : sink
        int unsigned stall;
        int unsigned span;
        logic        quiet_out;
        stall     = 0;
        span      = 0;
        quiet_out = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_output(out_re, out_im, last);
            if (span == 0)
            begin
                span      = 256;
                quiet_out = ($urandom_range(0, 3) == 0);
            end
            span--;
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_out && $urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    initial
    begin : stimulus
        int unsigned           sent;
        int unsigned           phase;
        int unsigned           n_burst;
        int unsigned           n_items;
        int unsigned           base;
        logic [CFG_DATA_W-1:0] l_val;
        logic [CFG_DATA_W-1:0] m_val;
        logic [CFG_DATA_W-1:0] t_val;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_INTERP;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_SAMPLE;
        sample_re    = '0;
        sample_im    = '0;
        coef_index   = '0;
        coef_re      = '0;
        coef_im      = '0;
        out_ready    = 1'b0;
        hold_request = 1'b0;
        quiet_in     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_load(6'd0, 16'sh7fff, 16'sh7fff);
        send_load(6'd1, 16'sh8000, 16'sh8000);
        send_load(6'd63, 16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        drain();
        // zero factors act as one, tap count clips to the store size
        apply_setting(7'd0, 7'd0, 7'd127, 1'b1);
        send_sample(16'sh0001, 16'shffff);
        drain();
        // factors above the limit clip to sixteen
        apply_setting(7'h7f, 7'h5f, 7'd64, 1'b0);
        repeat (3) send_sample(rand_q15(), rand_q15());
        drain();
        // fewer taps than phases
        apply_setting(7'd3, 7'd16, 7'd2, 1'b0);
        repeat (3) send_sample(rand_q15(), rand_q15());
        drain();
        // counter may now sit at or beyond the new decimation factor
        apply_setting(7'd5, 7'd2, 7'd64, 1'b0);
        repeat (3) send_sample(rand_q15(), rand_q15());
        send_load(6'd7, rand_q15(), rand_q15());
        send_sample(rand_q15(), rand_q15());

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            if (phase == 1)
            begin
                l_val = 7'd4;
                m_val = 7'd1;
                t_val = 7'd32;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                l_val = CFG_DATA_W'($urandom_range(0, 127));
                m_val = CFG_DATA_W'($urandom_range(0, 127));
                t_val = CFG_DATA_W'($urandom_range(0, 127));
            end
            else
            begin
                l_val = CFG_DATA_W'($urandom_range(1, 16));
                m_val = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(1, 4)) :
                                               CFG_DATA_W'($urandom_range(1, 16));
                t_val = CFG_DATA_W'($urandom_range(1, 64));
            end
            apply_setting(l_val, m_val, t_val, $urandom_range(0, 3) == 0);
            quiet_in = ($urandom_range(0, 3) == 0);

            n_burst = $urandom_range(2, 12);
            base    = $urandom_range(0, MAX_TAPS - 1);
            for (int unsigned k = 0; k < n_burst; k++)
                send_load(TAP_AW'((base + k) % MAX_TAPS), rand_q15(), rand_q15());

            if (phase == 1)
                hold_request = 1'b1;
            n_items = $urandom_range(12, 30);
            repeat (n_items)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_load(TAP_AW'($urandom_range(0, MAX_TAPS - 1)),
                              rand_q15(), rand_q15());
                else
                    send_sample(rand_q15(), rand_q15());
            end
            sent += n_burst + n_items;
            phase++;
        end
        drain();

        if (sb.mismatches == 0 && sb.pending_out.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hdl/pfr_pkg.sv
hdl/polyphase_resampling_fir.sv
hdl/pfr_checker.sv
dv/polyphase_resampling_fir_test.sv
